// ===== rtl/counter_multiplex_estimator_macros.svh =====
// ----------------------------------------------------------------------------
// Counter multiplex estimator assertion macros
// Shared concurrent assertion forms for the estimator RTL.
// ----------------------------------------------------------------------------
`ifndef COUNTER_MULTIPLEX_ESTIMATOR_MACROS_SVH
`define COUNTER_MULTIPLEX_ESTIMATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CME_ASSERT_IMPLY(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define CME_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/cme_pkg.sv =====
// ----------------------------------------------------------------------------
// Counter multiplex estimator package
// Shared widths and formula selection codes.
// ----------------------------------------------------------------------------
package cme_pkg;

  // Width of every count and time value.
  localparam int DW = 64;

  // Formula selected for an item.
  typedef logic [1:0] mode_t;
  localparam mode_t MODE_NONE   = 2'd0;
  localparam mode_t MODE_FIRST  = 2'd1;
  localparam mode_t MODE_TRAP   = 2'd2;
  localparam mode_t MODE_EXTRAP = 2'd3;

endpackage

// ===== rtl/counter_multiplex_estimator.sv =====
// ----------------------------------------------------------------------------
// Counter multiplex estimator
// Estimates multiplexed performance counter counts by first-sample scaling,
// trapezoid interpolation or extrapolation, one item per cycle unless the output stalls.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on the s_ channel: s_tuser holds the command
//   (0 interpolate, 1 extrapolate), s_tdata holds the held count and the
//   nine 64-bit samples. Each item yields exactly one result item on the
//   m_ channel: m_tdata is the estimate, m_tuser the divide error flag.
//   The datapath is a pipeline of 135 register stages: input register,
//   operand stage, a two-stage multiplier, a 64-stage divider, a second
//   two-stage multiplier, a second 64-stage divider and the output
//   register. One item is taken every cycle while the output drains. When
//   the receiver holds m_tready low with a result waiting, the whole
//   pipeline freezes and s_tready drops; nothing is lost or repeated, and
//   empty stages keep filling only as the output drains. Reset clears all
//   valid bits; the block holds no other state.
// ----------------------------------------------------------------------------
`include "counter_multiplex_estimator_macros.svh"

module counter_multiplex_estimator
  import cme_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // held_measurements[1:0], newest count, newest enabled time, newest
  // counter time, previous count, previous enabled time, previous counter
  // time, event_time_enabled, event_time_monitored, accumulated count,
  // then 6 zero bits.
  input  logic [583:0] s_tdata,
  // command
  input  logic [0:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // estimate
  output logic [63:0]  m_tdata,
  // divide_error
  output logic [0:0]   m_tuser
);

  typedef struct packed {
    mode_t         mode;
    logic          err;
    logic [DW-1:0] d;
    logic [DW-1:0] cc;
    logic [DW-1:0] pc;
    logic [DW-1:0] ph;
    logic [DW-1:0] ch;
    logic [DW-1:0] den3;
    logic [DW-1:0] rc;
  } sb1_t;

  typedef struct packed {
    mode_t         mode;
    logic          err;
    logic [DW-1:0] d;
    logic [DW-1:0] cc;
    logic [DW-1:0] pc;
    logic [DW-1:0] rc;
  } sb2_t;

  typedef struct packed {
    mode_t         mode;
    logic          err;
    logic [DW-1:0] d;
    logic [DW-1:0] t1;
    logic [DW-1:0] qs;
    logic [DW-1:0] rc;
  } sb3_t;

  typedef struct packed {
    mode_t         mode;
    logic          err;
    logic [DW-1:0] t1;
    logic [DW-1:0] qs;
    logic [DW-1:0] rc;
  } sb4_t;

  // Global advance: move whenever the output register is free or drains.
  logic ce;
  assign ce       = !m_tvalid || m_tready;
  assign s_tready = ce;

  // Input register.
  logic          v0;
  logic          cmd0;
  logic [1:0]    held0;
  logic [DW-1:0] cc0, ce0, ch0, pc0, pe0, ph0, ete0, etm0, rc0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (ce) begin
      v0 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      cmd0  <= s_tuser[0];
      held0 <= s_tdata[1:0];
      cc0   <= s_tdata[65:2];
      ce0   <= s_tdata[129:66];
      ch0   <= s_tdata[193:130];
      pc0   <= s_tdata[257:194];
      pe0   <= s_tdata[321:258];
      ph0   <= s_tdata[385:322];
      ete0  <= s_tdata[449:386];
      etm0  <= s_tdata[513:450];
      rc0   <= s_tdata[577:514];
    end
  end

  // Operand stage: formula choice, window width and its divisor.
  mode_t         mode0;
  logic [DW-1:0] w0;
  logic          v1;
  mode_t         mode1;
  logic [DW-1:0] w1, d1, xc1, cc1, pc1, ph1, ch1, den31, rc1;

  always_comb begin
    priority if (held0 == 2'd0) begin
      mode0 = MODE_NONE;
    end else if (cmd0) begin
      mode0 = MODE_EXTRAP;
    end else if (held0 == 2'd1) begin
      mode0 = MODE_FIRST;
    end else begin
      mode0 = MODE_TRAP;
    end
  end

  assign w0 = ce0 - pe0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ce) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      mode1 <= mode0;
      w1    <= w0;
      d1    <= {w0[DW-2:0], 1'b0} - ch0;
      xc1   <= (mode0 == MODE_FIRST) ? ete0 : (ete0 - ce0);
      cc1   <= cc0;
      pc1   <= pc0;
      ph1   <= ph0;
      ch1   <= ch0;
      den31 <= (mode0 == MODE_FIRST) ? etm0 : ch0;
      rc1   <= rc0;
    end
  end

  // Zero divisor check for the chosen formula.
  logic err1;
  always_comb begin
    unique case (mode1)
      MODE_NONE:   err1 = 1'b0;
      MODE_FIRST:  err1 = (den31 == '0);
      MODE_TRAP:   err1 = (ph1 == '0) || (ch1 == '0) || (d1 == '0);
      MODE_EXTRAP: err1 = (ch1 == '0);
      default:     err1 = 1'b0;
    endcase
  end

  // First multiply: pc*w, w*w and the single-term numerator.
  sb1_t          sb1_in, sb1_out;
  logic [DW-1:0] m1_a [3];
  logic [DW-1:0] m1_b [3];
  logic [DW-1:0] m1_p [3];
  logic          m1_v;

  assign sb1_in = '{mode: mode1, err: err1, d: d1, cc: cc1, pc: pc1, ph: ph1,
                    ch: ch1, den3: den31, rc: rc1};
  assign m1_a = '{pc1, w1, xc1};
  assign m1_b = '{w1, w1, cc1};

  cme_mul #(.W(DW), .LANES(3), .SBW($bits(sb1_t))) u_mul1 (
    .clk      (clk),
    .rst      (rst),
    .en       (ce),
    .in_valid (v1),
    .a        (m1_a),
    .b        (m1_b),
    .sb_in    (sb1_in),
    .out_valid(m1_v),
    .prod     (m1_p),
    .sb_out   (sb1_out)
  );

  // First divide: t1, (w*w)/ch, (w*w)/ph and the single-term quotient.
  sb2_t          sb2_in, sb2_out;
  logic [DW-1:0] d1_n [4];
  logic [DW-1:0] d1_d [4];
  logic [DW-1:0] d1_q [4];
  logic          d1_v;

  assign sb2_in = '{mode: sb1_out.mode, err: sb1_out.err, d: sb1_out.d,
                    cc: sb1_out.cc, pc: sb1_out.pc, rc: sb1_out.rc};
  assign d1_n = '{m1_p[0], m1_p[1], m1_p[1], m1_p[2]};
  assign d1_d = '{sb1_out.ph, sb1_out.ch, sb1_out.ph, sb1_out.den3};

  cme_div #(.W(DW), .LANES(4), .SBW($bits(sb2_t))) u_div1 (
    .clk      (clk),
    .rst      (rst),
    .en       (ce),
    .in_valid (m1_v),
    .num      (d1_n),
    .den      (d1_d),
    .sb_in    (sb2_in),
    .out_valid(d1_v),
    .quo      (d1_q),
    .sb_out   (sb2_out)
  );

  // Second multiply: scale the trapezoid quotients by the counts.
  sb3_t          sb3_in, sb3_out;
  logic [DW-1:0] m2_a [2];
  logic [DW-1:0] m2_b [2];
  logic [DW-1:0] m2_p [2];
  logic          m2_v;

  assign sb3_in = '{mode: sb2_out.mode, err: sb2_out.err, d: sb2_out.d,
                    t1: d1_q[0], qs: d1_q[3], rc: sb2_out.rc};
  assign m2_a = '{d1_q[1], d1_q[2]};
  assign m2_b = '{sb2_out.cc, sb2_out.pc};

  cme_mul #(.W(DW), .LANES(2), .SBW($bits(sb3_t))) u_mul2 (
    .clk      (clk),
    .rst      (rst),
    .en       (ce),
    .in_valid (d1_v),
    .a        (m2_a),
    .b        (m2_b),
    .sb_in    (sb3_in),
    .out_valid(m2_v),
    .prod     (m2_p),
    .sb_out   (sb3_out)
  );

  // Second divide: both trapezoid terms over d.
  sb4_t          sb4_in, fin_sb;
  logic [DW-1:0] d2_n [2];
  logic [DW-1:0] d2_d [2];
  logic [DW-1:0] d2_q [2];
  logic          fin_v;

  assign sb4_in = '{mode: sb3_out.mode, err: sb3_out.err, t1: sb3_out.t1,
                    qs: sb3_out.qs, rc: sb3_out.rc};
  assign d2_n = '{m2_p[0], m2_p[1]};
  assign d2_d = '{sb3_out.d, sb3_out.d};

  cme_div #(.W(DW), .LANES(2), .SBW($bits(sb4_t))) u_div2 (
    .clk      (clk),
    .rst      (rst),
    .en       (ce),
    .in_valid (m2_v),
    .num      (d2_n),
    .den      (d2_d),
    .sb_in    (sb4_in),
    .out_valid(fin_v),
    .quo      (d2_q),
    .sb_out   (fin_sb)
  );

  // Final combine for the chosen formula.
  logic [DW-1:0] est_next;
  always_comb begin
    unique case (fin_sb.mode)
      MODE_NONE:   est_next = '0;
      MODE_FIRST:  est_next = fin_sb.qs;
      MODE_TRAP:   est_next = (fin_sb.t1 + d2_q[0]) - d2_q[1];
      MODE_EXTRAP: est_next = fin_sb.rc + fin_sb.qs;
      default:     est_next = '0;
    endcase
    if (fin_sb.err) begin
      est_next = '1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ce) begin
      m_tvalid <= fin_v;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      m_tdata    <= est_next;
      m_tuser[0] <= fin_sb.err;
    end
  end

  // Conditions watched by the checks below.
  logic out_err, out_zero, fin_none, s_take;
  assign out_err  = m_tvalid && m_tuser[0];
  assign out_zero = (m_tdata == '0) && !m_tuser[0];
  assign fin_none = ce && fin_v && (fin_sb.mode == MODE_NONE);
  assign s_take   = s_tvalid && s_tready;

  // A flagged result always carries the all-ones estimate.
  `CME_ASSERT_IMPLY(a_err_all_ones, clk, rst, out_err, m_tdata == '1, "bad error estimate")
  // An item with nothing held comes out as a clean zero.
  `CME_ASSERT_NEXT(a_none_is_zero, clk, rst, fin_none, out_zero, "empty item not zero")
  // An accepted item lands in the input register.
  `CME_ASSERT_NEXT(a_accept_lands, clk, rst, s_take, v0, "accepted item not captured")

endmodule

// ===== rtl/cme_mul.sv =====
// ----------------------------------------------------------------------------
// Pipelined low-half multiplier
// Multi-lane W x W multiply keeping the low W bits, built from half-width
// partial products over two register stages, with a sideband that travels
// alongside the operands.
// ----------------------------------------------------------------------------
module cme_mul
  import cme_pkg::*;
#(
  parameter int W     = 64,
  parameter int LANES = 1,
  parameter int SBW   = 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  logic [W-1:0]   a [LANES],
  input  logic [W-1:0]   b [LANES],
  input  logic [SBW-1:0] sb_in,
  output logic           out_valid,
  output logic [W-1:0]   prod [LANES],
  output logic [SBW-1:0] sb_out
);

  localparam int H = W / 2;

  logic [W-1:0]   ll_r [LANES];
  logic [H-1:0]   x1_r [LANES];
  logic [H-1:0]   x2_r [LANES];
  logic [W-1:0]   p_r  [LANES];
  logic [SBW-1:0] sb1_r, sb2_r;
  logic           v1_r, v2_r;

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [W-1:0] ll, c1, c2;

    // Partial products; the cross terms only matter in their low half.
    assign ll = a[l][H-1:0] * b[l][H-1:0];
    assign c1 = a[l][H-1:0] * b[l][W-1:H];
    assign c2 = a[l][W-1:H] * b[l][H-1:0];

    always_ff @(posedge clk) begin
      if (en) begin
        ll_r[l] <= ll;
        x1_r[l] <= c1[H-1:0];
        x2_r[l] <= c2[H-1:0];
        p_r[l]  <= ll_r[l] + {x1_r[l] + x2_r[l], {H{1'b0}}};
      end
    end

    assign prod[l] = p_r[l];
  end

  // Sideband and valid follow the two stages.
  always_ff @(posedge clk) begin
    if (en) begin
      sb1_r <= sb_in;
      sb2_r <= sb1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  assign out_valid = v2_r;
  assign sb_out    = sb2_r;

endmodule

// ===== rtl/cme_div.sv =====
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Multi-lane unsigned W / W divider, one quotient bit per register stage,
// W stages deep. A zero divisor yields an all-ones quotient; the caller
// flags that case separately.
// ----------------------------------------------------------------------------
module cme_div
  import cme_pkg::*;
#(
  parameter int W     = 64,
  parameter int LANES = 1,
  parameter int SBW   = 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  logic [W-1:0]   num [LANES],
  input  logic [W-1:0]   den [LANES],
  input  logic [SBW-1:0] sb_in,
  output logic           out_valid,
  output logic [W-1:0]   quo [LANES],
  output logic [SBW-1:0] sb_out
);

  logic [W-1:0]   rem_r [W][LANES];
  logic [W-1:0]   num_r [W][LANES];
  logic [W-1:0]   den_r [W][LANES];
  logic [SBW-1:0] sb_r  [W];
  logic           v_r   [W];

  for (genvar s = 0; s < W; s++) begin : g_stage
    logic [W-1:0]   rem_i [LANES];
    logic [W-1:0]   num_i [LANES];
    logic [W-1:0]   den_i [LANES];
    logic [SBW-1:0] sb_i;
    logic           v_i;

    // Stage inputs come from the ports for the first stage.
    if (s == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          rem_i[l] = '0;
          num_i[l] = num[l];
          den_i[l] = den[l];
        end
        sb_i = sb_in;
        v_i  = in_valid;
      end
    end else begin : g_rest
      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          rem_i[l] = rem_r[s-1][l];
          num_i[l] = num_r[s-1][l];
          den_i[l] = den_r[s-1][l];
        end
        sb_i = sb_r[s-1];
        v_i  = v_r[s-1];
      end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [W:0] part, trial;

      // Bring down the next dividend bit and try a subtract.
      assign part  = {rem_i[l], num_i[l][W-1]};
      assign trial = part - {1'b0, den_i[l]};

      always_ff @(posedge clk) begin
        if (en) begin
          if (!trial[W]) begin
            rem_r[s][l] <= trial[W-1:0];
          end else begin
            rem_r[s][l] <= part[W-1:0];
          end
          num_r[s][l] <= {num_i[l][W-2:0], ~trial[W]};
          den_r[s][l] <= den_i[l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sb_r[s] <= sb_i;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_i;
      end
    end
  end

  // The dividend register has been shifted full of quotient bits.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      quo[l] = num_r[W-1][l];
    end
  end

  assign out_valid = v_r[W-1];
  assign sb_out    = sb_r[W-1];

endmodule
